// ===== rtl/sphere_sphere_contact_core_macros.svh =====
// Assertion macros shared by the sphere contact RTL.
`ifndef SPHERE_SPHERE_CONTACT_CORE_MACROS_SVH
`define SPHERE_SPHERE_CONTACT_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
// Types and constants shared by the sphere contact pipeline.
package ssc_pkg;

    localparam int NORM_BITS = 30;
    localparam int SQ_STEPS  = 34;
    localparam int SQ_IN_W   = 2 * SQ_STEPS;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int REM_W     = SQ_STEPS + 3;
    localparam int MAG_W     = 33;
    localparam int DIV_STEPS = NORM_BITS + 1;
    localparam logic [62:0] RND_HALF = 63'(1) << (NORM_BITS - 1);

    // Carried alongside the first square root.
    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0][31:0]       ac;
        logic [2:0][31:0]       bc;
        logic [30:0]            rb;
        logic [31:0]            rsum;
    } geo_t;

    // Carried alongside the normal division.
    typedef struct packed {
        logic             hit;
        logic             len_zero;
        logic [2:0]       neg;
        logic [2:0][31:0] ac;
        logic [2:0][31:0] bc;
        logic [30:0]      rb;
    } dside_t;

    // Carried alongside the second square root.
    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] pt;
        logic [2:0][31:0] nrm;
    } fside_t;

    // One finished result item.
    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] pt;
        logic [31:0]      cdist;
        logic [2:0][31:0] nrm;
    } result_t;

endpackage

// ===== rtl/ssc_sqrt_cell.sv =====
// One digit step of the pipelined integer square root.
module ssc_sqrt_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ssc_pkg::SQ_IN_W-1:0]  in_s,
    input  logic [ssc_pkg::REM_W-1:0]    in_rem,
    input  logic [ssc_pkg::ROOT_W-1:0]   in_root,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [ssc_pkg::SQ_IN_W-1:0]  out_s,
    output logic [ssc_pkg::REM_W-1:0]    out_rem,
    output logic [ssc_pkg::ROOT_W-1:0]   out_root,
    output logic [SIDE_W-1:0]            out_side
);

    logic                        valid_reg;
    logic [ssc_pkg::SQ_IN_W-1:0] s_reg;
    logic [ssc_pkg::REM_W-1:0]   rem_reg;
    logic [ssc_pkg::ROOT_W-1:0]  root_reg;
    logic [SIDE_W-1:0]           side_reg;
    logic [ssc_pkg::REM_W-1:0]   rem_sh;
    logic [ssc_pkg::REM_W-1:0]   trial;
    logic                        ge;
    logic [ssc_pkg::REM_W-1:0]   rem_next;
    logic [ssc_pkg::ROOT_W-1:0]  root_next;

    // Bring down the next two radicand bits and try to set the next root bit.
    always_comb begin
        rem_sh    = {in_rem[ssc_pkg::REM_W-3:0], in_s[ssc_pkg::SQ_IN_W-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[ssc_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= {in_s[ssc_pkg::SQ_IN_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/ssc_div_cell.sv =====
// One quotient bit of the three-lane normal divider.
module ssc_div_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [31:0]                         in_d,
    input  logic [2:0][ssc_pkg::MAG_W-1:0]      in_r,
    input  logic [2:0][ssc_pkg::NORM_BITS:0]    in_q,
    input  ssc_pkg::dside_t                     in_side,
    output logic                                out_valid,
    output logic [31:0]                         out_d,
    output logic [2:0][ssc_pkg::MAG_W-1:0]      out_r,
    output logic [2:0][ssc_pkg::NORM_BITS:0]    out_q,
    output ssc_pkg::dside_t                     out_side
);

    logic                                valid_reg;
    logic [31:0]                         d_reg;
    logic [2:0][ssc_pkg::MAG_W-1:0]      r_reg;
    logic [2:0][ssc_pkg::NORM_BITS:0]    q_reg;
    ssc_pkg::dside_t                     side_reg;
    logic [2:0][ssc_pkg::MAG_W-1:0]      r_next;
    logic [2:0][ssc_pkg::NORM_BITS:0]    q_next;
    logic [2:0]                          ge;
    logic [2:0][ssc_pkg::MAG_W-1:0]      r_sel;

    // Restoring division step on each lane against the shared divisor.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ge[i]     = (in_r[i] >= {1'b0, in_d});
            r_sel[i]  = ge[i] ? (in_r[i] - {1'b0, in_d}) : in_r[i];
            r_next[i] = {r_sel[i][ssc_pkg::MAG_W-2:0], 1'b0};
            q_next[i] = {in_q[i][ssc_pkg::NORM_BITS-1:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= in_d;
            r_reg    <= r_next;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/sphere_sphere_contact_core.sv =====
// Top level of the pipelined sphere-sphere contact test.
//
// Input channel s_*: one item per query, two spheres as signed Q16.16 centres
// and unsigned radii. Result channel m_*: hit flag, contact point, distance
// from the point to centre A, and the unit normal in signed Q2.30.
// An item is moved on a channel when its valid and ready are both high.
//
// Throughput is one item per clock while the skid register is empty. From
// acceptance to m_valid an item passes nine arithmetic stages, two 34-cell
// square-root chains and a 31-cell divider chain, one cell per result bit,
// and the output register.
//
// All stages advance together while the skid register is empty. When the
// receiver holds m_ready low, the output register keeps its item and the next
// finished item drops into the skid register; only then does s_ready fall.
//
// aresetn is synchronous and active low. It clears every valid bit, so the
// pipeline comes up empty and ready; data registers are not reset.
// A miss reports hit low, zero point and normal, and distance all ones.
`include "sphere_sphere_contact_core_macros.svh"

module sphere_sphere_contact_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_a_center_x,
    input  logic [31:0] s_a_center_y,
    input  logic [31:0] s_a_center_z,
    input  logic [30:0] s_a_radius,
    input  logic [31:0] s_b_center_x,
    input  logic [31:0] s_b_center_y,
    input  logic [31:0] s_b_center_z,
    input  logic [30:0] s_b_radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [31:0] m_point_x,
    output logic [31:0] m_point_y,
    output logic [31:0] m_point_z,
    output logic [31:0] m_contact_distance,
    output logic [31:0] m_normal_x,
    output logic [31:0] m_normal_y,
    output logic [31:0] m_normal_z
);

    localparam int GEO_W = $bits(ssc_pkg::geo_t);
    localparam int FS_W  = $bits(ssc_pkg::fside_t);
    localparam int SQN   = ssc_pkg::SQ_STEPS;
    localparam int DVN   = ssc_pkg::DIV_STEPS;
    localparam int MW    = ssc_pkg::MAG_W;
    localparam int NB    = ssc_pkg::NORM_BITS;

    logic en;

    logic [2:0][31:0]    ac_in;
    logic [2:0][31:0]    bc_in;
    logic [2:0][MW-1:0]  diff_next;
    ssc_pkg::geo_t       geo1_next;

    // Stage 1: center difference and its magnitude.
    logic                v1_reg;
    ssc_pkg::geo_t       geo1_reg;
    // Stage 2: squares.
    logic                v2_reg;
    ssc_pkg::geo_t       geo2_reg;
    logic [2:0][65:0]    sq1_reg;
    // Stage 3: sum of squares.
    logic                v3_reg;
    ssc_pkg::geo_t       geo3_reg;
    logic [ssc_pkg::SQ_IN_W-1:0] ssum1_reg;

    // First square-root chain.
    logic                         r1_v    [0:SQN];
    logic [ssc_pkg::SQ_IN_W-1:0]  r1_s    [0:SQN];
    logic [ssc_pkg::REM_W-1:0]    r1_rem  [0:SQN];
    logic [ssc_pkg::ROOT_W-1:0]   r1_root [0:SQN];
    logic [GEO_W-1:0]             r1_side [0:SQN];

    // Stage 4: hit decision, divider setup.
    ssc_pkg::geo_t               geo4;
    logic [ssc_pkg::ROOT_W-1:0]  len4;
    ssc_pkg::dside_t             ds4_next;
    logic                        v4_reg;
    logic [31:0]                 d4_reg;
    logic [2:0][MW-1:0]          r4_reg;
    ssc_pkg::dside_t             ds4_reg;

    // Divider chain.
    logic                        dv_v    [0:DVN];
    logic [31:0]                 dv_d    [0:DVN];
    logic [2:0][MW-1:0]          dv_r    [0:DVN];
    logic [2:0][NB:0]            dv_q    [0:DVN];
    ssc_pkg::dside_t             dv_side [0:DVN];

    // Stage 5: normal and scaled offset.
    ssc_pkg::dside_t             ds5;
    logic [2:0][NB:0]            nq5;
    logic [2:0][31:0]            nrm5_next;
    logic                        v5_reg;
    logic                        hit5_reg;
    logic [2:0]                  neg5_reg;
    logic [2:0][31:0]            ac5_reg;
    logic [2:0][31:0]            bc5_reg;
    logic [2:0][31:0]            nrm5_reg;
    logic [2:0][61:0]            prod5_reg;

    // Stage 6: rounded offset added to center B, saturated.
    logic [2:0][62:0]            rsum6;
    logic [2:0][32:0]            rnd6;
    logic [2:0][33:0]            pw6;
    logic [2:0][31:0]            pt6_next;
    logic                        v6_reg;
    logic                        hit6_reg;
    logic [2:0][31:0]            ac6_reg;
    logic [2:0][31:0]            nrm6_reg;
    logic [2:0][31:0]            pt6_reg;

    // Stage 7: point minus center A.
    logic [2:0][MW-1:0]          dp7;
    logic [2:0][MW-1:0]          mag7_next;
    logic                        v7_reg;
    ssc_pkg::fside_t             fs7_reg;
    logic [2:0][MW-1:0]          mag7_reg;
    // Stage 8: squares.
    logic                        v8_reg;
    ssc_pkg::fside_t             fs8_reg;
    logic [2:0][65:0]            sq8_reg;
    // Stage 9: sum of squares.
    logic                        v9_reg;
    ssc_pkg::fside_t             fs9_reg;
    logic [ssc_pkg::SQ_IN_W-1:0] ssum9_reg;

    // Second square-root chain.
    logic                         r2_v    [0:SQN];
    logic [ssc_pkg::SQ_IN_W-1:0]  r2_s    [0:SQN];
    logic [ssc_pkg::REM_W-1:0]    r2_rem  [0:SQN];
    logic [ssc_pkg::ROOT_W-1:0]   r2_root [0:SQN];
    logic [FS_W-1:0]              r2_side [0:SQN];

    // Output register and skid register.
    ssc_pkg::fside_t  fsf;
    ssc_pkg::result_t res_next;
    logic             last_v;
    logic             out_v_reg;
    logic             skid_v_reg;
    ssc_pkg::result_t out_reg;
    ssc_pkg::result_t skid_reg;
    logic             out_free;

    // The pipeline moves whenever the skid register can take a stalled item.
    assign en      = !skid_v_reg;
    assign s_ready = en;

    // Stage 1 inputs: difference of centers and radius sum.
    always_comb begin
        ac_in = {s_a_center_z, s_a_center_y, s_a_center_x};
        bc_in = {s_b_center_z, s_b_center_y, s_b_center_x};
        for (int i = 0; i < 3; i++) begin
            diff_next[i]    = {ac_in[i][31], ac_in[i]} - {bc_in[i][31], bc_in[i]};
            geo1_next.neg[i] = diff_next[i][MW-1];
            geo1_next.mag[i] = diff_next[i][MW-1] ? (MW'(0) - diff_next[i]) : diff_next[i];
        end
        geo1_next.ac   = ac_in;
        geo1_next.bc   = bc_in;
        geo1_next.rb   = s_b_radius;
        geo1_next.rsum = {1'b0, s_a_radius} + {1'b0, s_b_radius};
    end

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= r1_v[SQN];
            v5_reg <= dv_v[DVN];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // Stages 1 to 3: squares and their sum for the center distance.
    always_ff @(posedge aclk) begin
        if (en) begin
            geo1_reg <= geo1_next;
            geo2_reg <= geo1_reg;
            for (int i = 0; i < 3; i++) begin
                sq1_reg[i] <= 66'(geo1_reg.mag[i]) * 66'(geo1_reg.mag[i]);
            end
            geo3_reg  <= geo2_reg;
            ssum1_reg <= ssc_pkg::SQ_IN_W'(sq1_reg[0]) + ssc_pkg::SQ_IN_W'(sq1_reg[1])
                       + ssc_pkg::SQ_IN_W'(sq1_reg[2]);
        end
    end

    assign r1_v[0]    = v3_reg;
    assign r1_s[0]    = ssum1_reg;
    assign r1_rem[0]  = '0;
    assign r1_root[0] = '0;
    assign r1_side[0] = GEO_W'(geo3_reg);

    // Center distance, one root bit per cell.
    for (genvar k = 0; k < SQN; k++) begin : g_root1
        ssc_sqrt_cell #(.SIDE_W(GEO_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (r1_v[k]),
            .in_s      (r1_s[k]),
            .in_rem    (r1_rem[k]),
            .in_root   (r1_root[k]),
            .in_side   (r1_side[k]),
            .out_valid (r1_v[k+1]),
            .out_s     (r1_s[k+1]),
            .out_rem   (r1_rem[k+1]),
            .out_root  (r1_root[k+1]),
            .out_side  (r1_side[k+1])
        );
    end

    // Stage 4: compare the length with the radius sum.
    always_comb begin
        geo4 = ssc_pkg::geo_t'(r1_side[SQN]);
        len4 = r1_root[SQN];
        ds4_next.hit      = (len4 < {2'b00, geo4.rsum});
        ds4_next.len_zero = (len4 == '0);
        ds4_next.neg      = geo4.neg;
        ds4_next.ac       = geo4.ac;
        ds4_next.bc       = geo4.bc;
        ds4_next.rb       = geo4.rb;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d4_reg  <= len4[31:0];
            r4_reg  <= geo4.mag;
            ds4_reg <= ds4_next;
        end
    end

    assign dv_v[0]    = v4_reg;
    assign dv_d[0]    = d4_reg;
    assign dv_r[0]    = r4_reg;
    assign dv_q[0]    = '0;
    assign dv_side[0] = ds4_reg;

    // Normal components, one quotient bit per cell.
    for (genvar k = 0; k < DVN; k++) begin : g_div
        ssc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[k]),
            .in_d      (dv_d[k]),
            .in_r      (dv_r[k]),
            .in_q      (dv_q[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_v[k+1]),
            .out_d     (dv_d[k+1]),
            .out_r     (dv_r[k+1]),
            .out_q     (dv_q[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    // Stage 5: signed normal and normal times radius B.
    always_comb begin
        ds5 = dv_side[DVN];
        for (int i = 0; i < 3; i++) begin
            nq5[i]       = ds5.len_zero ? '0 : dv_q[DVN][i];
            nrm5_next[i] = ds5.neg[i] ? (32'(0) - 32'(nq5[i])) : 32'(nq5[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit5_reg <= ds5.hit;
            neg5_reg <= ds5.neg;
            ac5_reg  <= ds5.ac;
            bc5_reg  <= ds5.bc;
            nrm5_reg <= nrm5_next;
            for (int i = 0; i < 3; i++) begin
                prod5_reg[i] <= 62'(nq5[i]) * 62'(ds5.rb);
            end
        end
    end

    // Stage 6: round half away from zero, add to center B, saturate.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum6[i] = 63'(prod5_reg[i]) + ssc_pkg::RND_HALF;
            rnd6[i]  = rsum6[i][62:NB];
            pw6[i]   = neg5_reg[i] ? ({{2{bc5_reg[i][31]}}, bc5_reg[i]} - {1'b0, rnd6[i]})
                                   : ({{2{bc5_reg[i][31]}}, bc5_reg[i]} + {1'b0, rnd6[i]});
            if (!pw6[i][33] && (pw6[i][32:31] != 2'b00)) begin
                pt6_next[i] = 32'h7FFF_FFFF;
            end else if (pw6[i][33] && (pw6[i][32:31] != 2'b11)) begin
                pt6_next[i] = 32'h8000_0000;
            end else begin
                pt6_next[i] = pw6[i][31:0];
            end
        end
    end

    // Stage 7 inputs: offset from the point back to center A.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dp7[i]       = {pt6_reg[i][31], pt6_reg[i]} - {ac6_reg[i][31], ac6_reg[i]};
            mag7_next[i] = dp7[i][MW-1] ? (MW'(0) - dp7[i]) : dp7[i];
        end
    end

    // Stages 6 to 9: point, offset, squares and their sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            hit6_reg    <= hit5_reg;
            ac6_reg     <= ac5_reg;
            nrm6_reg    <= nrm5_reg;
            pt6_reg     <= pt6_next;
            fs7_reg.hit <= hit6_reg;
            fs7_reg.pt  <= pt6_reg;
            fs7_reg.nrm <= nrm6_reg;
            mag7_reg    <= mag7_next;
            fs8_reg     <= fs7_reg;
            for (int i = 0; i < 3; i++) begin
                sq8_reg[i] <= 66'(mag7_reg[i]) * 66'(mag7_reg[i]);
            end
            fs9_reg   <= fs8_reg;
            ssum9_reg <= ssc_pkg::SQ_IN_W'(sq8_reg[0]) + ssc_pkg::SQ_IN_W'(sq8_reg[1])
                       + ssc_pkg::SQ_IN_W'(sq8_reg[2]);
        end
    end

    assign r2_v[0]    = v9_reg;
    assign r2_s[0]    = ssum9_reg;
    assign r2_rem[0]  = '0;
    assign r2_root[0] = '0;
    assign r2_side[0] = FS_W'(fs9_reg);

    // Contact distance, one root bit per cell.
    for (genvar k = 0; k < SQN; k++) begin : g_root2
        ssc_sqrt_cell #(.SIDE_W(FS_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (r2_v[k]),
            .in_s      (r2_s[k]),
            .in_rem    (r2_rem[k]),
            .in_root   (r2_root[k]),
            .in_side   (r2_side[k]),
            .out_valid (r2_v[k+1]),
            .out_s     (r2_s[k+1]),
            .out_rem   (r2_rem[k+1]),
            .out_root  (r2_root[k+1]),
            .out_side  (r2_side[k+1])
        );
    end

    // Final item: a miss reports zeros and the largest distance.
    always_comb begin
        fsf    = ssc_pkg::fside_t'(r2_side[SQN]);
        last_v = r2_v[SQN];
        res_next.hit = fsf.hit;
        if (fsf.hit) begin
            res_next.pt    = fsf.pt;
            res_next.nrm   = fsf.nrm;
            res_next.cdist = (r2_root[SQN][33:32] != 2'b00) ? 32'hFFFF_FFFF
                                                           : r2_root[SQN][31:0];
        end else begin
            res_next.pt    = '0;
            res_next.nrm   = '0;
            res_next.cdist = 32'hFFFF_FFFF;
        end
    end

    assign out_free = m_ready || !out_v_reg;

    // Output and skid valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= last_v;
            end
        end else if (!skid_v_reg && last_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    // Output and skid payload.
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_v_reg ? skid_reg : res_next;
        end else if (!skid_v_reg) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid            = out_v_reg;
    assign m_hit              = out_reg.hit;
    assign m_point_x          = out_reg.pt[0];
    assign m_point_y          = out_reg.pt[1];
    assign m_point_z          = out_reg.pt[2];
    assign m_contact_distance = out_reg.cdist;
    assign m_normal_x         = out_reg.nrm[0];
    assign m_normal_y         = out_reg.nrm[1];
    assign m_normal_z         = out_reg.nrm[2];

    // A held item in the skid register always has one waiting ahead of it.
    `SSC_ASSERT_SAME(a_skid_behind_out, aclk, aresetn, skid_v_reg, out_v_reg, "skid holds an item while output is empty")
    // A finished item arriving during a stall must land in the skid register.
    `SSC_ASSERT_NEXT(a_skid_fill, aclk, aresetn, out_v_reg && !m_ready && !skid_v_reg && last_v, skid_v_reg, "stalled item was lost")
    // A miss reports the largest distance and a zero point.
    `SSC_ASSERT_SAME(a_miss_fields, aclk, aresetn, out_v_reg && !out_reg.hit, (out_reg.cdist == 32'hFFFF_FFFF) && (out_reg.pt == '0), "miss item has wrong fields")
    // The normal x component stays within one in Q2.30.
    `SSC_ASSERT_SAME(a_normal_range, aclk, aresetn, out_v_reg, ($signed(out_reg.nrm[0]) <= 32'sh4000_0000) && ($signed(out_reg.nrm[0]) >= -32'sh4000_0000), "normal x out of range")

endmodule
